// ----- hdl/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared widths, status codes, register indexes and record types of the
// ARP cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int DEF_ENTRIES = 1024;
  localparam int DEF_IFACES  = 2;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 16;
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [TMO_W-1:0] OK_TMO_RST = 16'd60;
  localparam logic [TMO_W-1:0] NG_TMO_RST = 16'd1;

  // register index, taken from paddr[2]
  localparam logic REG_OK_TMO = 1'b0;
  localparam logic REG_NG_TMO = 1'b1;

  // entry status codes
  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_PEND = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;

  typedef struct packed {
    logic [1:0]        status;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] last_use;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] entry_index;
    logic             resolved;
    logic [MAC_W-1:0] mac_out;
    logic             added;
    logic             send_arp;
    logic             table_full;
  } result_t;

  typedef struct packed {
    logic load;
    logic first;
    logic scan;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/arpc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_if
// Request and result channels of the ARP cache, valid/ready handshake.
// ----------------------------------------------------------------------------
interface arpc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        iface;
  logic [arpc_pkg::IP_W-1:0]   ip_addr;
  logic                        has_mac;
  logic [arpc_pkg::MAC_W-1:0]  mac_addr;
  logic [arpc_pkg::TIME_W-1:0] now_sec;

  modport source (output valid, iface, ip_addr, has_mac, mac_addr, now_sec, input ready);
  modport sink (input valid, iface, ip_addr, has_mac, mac_addr, now_sec, output ready);
endinterface

interface arpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [arpc_pkg::IDX_W-1:0] entry_index;
  logic                       resolved;
  logic [arpc_pkg::MAC_W-1:0] mac_out;
  logic                       added;
  logic                       send_arp;
  logic                       table_full;

  modport source (output valid, entry_index, resolved, mac_out, added, send_arp, table_full,
                  input ready);
  modport sink (input valid, entry_index, resolved, mac_out, added, send_arp, table_full,
                output ready);
endinterface

// ----- hdl/arpc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer of one request: take the beat, scan the table, place a new
// entry, hand the result to the output register.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  arpc_pkg::stat_t stat,
  output arpc_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.first = 1'b1;
        state_nxt = stat.empty ? S_FINAL : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_nxt = S_DONE;
        end else if (stat.last) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_START))
    else $error("accepted beat did not start a scan");

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.hit) |=> (state_r == S_DONE))
    else $error("scan went on after a hit");
`endif

endmodule

// ----- hdl/arpc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_dp
// Entry memory, per-interface fill counters, scan evaluation, new-entry
// placement and the result register.
// ----------------------------------------------------------------------------
module arpc_dp #(
  parameter int ENTRIES = arpc_pkg::DEF_ENTRIES,
  parameter int IFACES  = arpc_pkg::DEF_IFACES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arpc_pkg::cmd_t                cmd,
  output arpc_pkg::stat_t               stat,
  input  logic [arpc_pkg::TMO_W-1:0]    ok_tmo,
  input  logic [arpc_pkg::TMO_W-1:0]    ng_tmo,
  input  logic                          in_iface,
  input  logic [arpc_pkg::IP_W-1:0]     in_ip_addr,
  input  logic                          in_has_mac,
  input  logic [arpc_pkg::MAC_W-1:0]    in_mac_addr,
  input  logic [arpc_pkg::TIME_W-1:0]   in_now_sec,
  input  logic                          out_ready,
  output logic                          out_valid,
  output arpc_pkg::result_t             out_res
);

  localparam int SW          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW          = $clog2(ENTRIES + 1);
  localparam int IW          = (IFACES > 1) ? $clog2(IFACES) : 1;
  localparam int IFACE_SLOTS = 1 << IW;
  localparam int MEM_DEPTH   = IFACE_SLOTS << SW;
  localparam int IDX_W       = arpc_pkg::IDX_W;
  localparam int TIME_W      = arpc_pkg::TIME_W;

  arpc_pkg::entry_t entry_mem [MEM_DEPTH];
  arpc_pkg::entry_t rd_entry_r;

  logic [IW-1:0]                 f_r;
  logic [arpc_pkg::IP_W-1:0]     ip_r;
  logic                          has_mac_r;
  logic [arpc_pkg::MAC_W-1:0]    mac_r;
  logic [TIME_W-1:0]             now_r;

  logic [CW-1:0]                 used_cnt_r [IFACE_SLOTS];
  logic [SW-1:0]                 idx_r;
  logic                          have_free_r;
  logic [SW-1:0]                 free_slot_r;
  arpc_pkg::result_t             res_r;
  arpc_pkg::result_t             res_nxt;
  logic                          out_valid_r;
  arpc_pkg::result_t             out_res_r;

  logic [CW-1:0]                 cnt_cur;
  logic [SW-1:0]                 rd_slot;
  logic [1:0]                    st;
  logic                          is_free;
  logic [TIME_W-1:0]             age;
  logic                          expd;
  logic                          match;
  logic                          hit;
  logic                          free_now;
  logic                          full;
  logic                          wr_en;
  logic [SW-1:0]                 wr_slot;
  arpc_pkg::entry_t              wr_data;
  logic                          res_en;
  logic [SW-1:0]                 new_slot;

  assign cnt_cur = used_cnt_r[f_r];
  assign rd_slot = cmd.first ? '0 : (idx_r + 1'b1);

  // entry under evaluation
  always_comb begin
    st      = rd_entry_r.status;
    is_free = (st == arpc_pkg::ST_FREE);
    age     = now_r - rd_entry_r.last_use;
    if (st == arpc_pkg::ST_OK) begin
      expd = (age > TIME_W'(ok_tmo));
    end else if (st == arpc_pkg::ST_PEND) begin
      expd = (age > TIME_W'(ng_tmo));
    end else begin
      expd = 1'b0;
    end
    match    = !is_free && (rd_entry_r.ip == ip_r);
    hit      = match && (has_mac_r || !((st == arpc_pkg::ST_PEND) && expd));
    free_now = !is_free && ((match && !hit) || (!match && expd));
  end

  assign full     = !have_free_r && (cnt_cur == CW'(ENTRIES));
  assign new_slot = have_free_r ? free_slot_r : cnt_cur[SW-1:0];

  // memory write and result
  always_comb begin
    wr_en   = 1'b0;
    wr_slot = idx_r;
    wr_data = rd_entry_r;
    res_en  = 1'b0;
    res_nxt = '0;
    if (cmd.scan) begin
      if (hit) begin
        res_en              = 1'b1;
        res_nxt.entry_index = IDX_W'(idx_r);
        res_nxt.resolved    = has_mac_r || (st == arpc_pkg::ST_OK);
        res_nxt.send_arp    = !(has_mac_r || (st == arpc_pkg::ST_OK));
        if (has_mac_r) begin
          res_nxt.mac_out = mac_r;
        end else if (st == arpc_pkg::ST_OK) begin
          res_nxt.mac_out = rd_entry_r.mac;
        end
        if (st == arpc_pkg::ST_OK) begin
          wr_en            = 1'b1;
          wr_data.last_use = now_r;
        end
        if (has_mac_r) begin
          wr_en          = 1'b1;
          wr_data.status = arpc_pkg::ST_OK;
          wr_data.mac    = mac_r;
        end
      end else if (free_now) begin
        wr_en          = 1'b1;
        wr_data.status = arpc_pkg::ST_FREE;
      end
    end else if (cmd.fin) begin
      res_en = 1'b1;
      if (full) begin
        res_nxt.table_full = 1'b1;
      end else begin
        wr_en               = 1'b1;
        wr_slot             = new_slot;
        wr_data.status      = has_mac_r ? arpc_pkg::ST_OK : arpc_pkg::ST_PEND;
        wr_data.ip          = ip_r;
        wr_data.mac         = has_mac_r ? mac_r : '0;
        wr_data.last_use    = now_r;
        res_nxt.entry_index = IDX_W'(new_slot);
        res_nxt.resolved    = has_mac_r;
        res_nxt.mac_out     = has_mac_r ? mac_r : '0;
        res_nxt.added       = 1'b1;
        res_nxt.send_arp    = !has_mac_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[{f_r, wr_slot}] <= wr_data;
    end
    rd_entry_r <= entry_mem[{f_r, rd_slot}];
  end

  // request payload, first free slot found and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r       <= (IFACES > 1) ? IW'(in_iface) : '0;
      ip_r      <= in_ip_addr;
      has_mac_r <= in_has_mac;
      mac_r     <= in_mac_addr;
      now_r     <= in_now_sec;
    end
    if (res_en) begin
      res_r <= res_nxt;
    end
    if (cmd.scan && (is_free || free_now) && !have_free_r) begin
      free_slot_r <= idx_r;
    end
    if (cmd.out_load) begin
      out_res_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      have_free_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < IFACE_SLOTS; k++) begin
        used_cnt_r[k] <= '0;
      end
    end else begin
      if (cmd.load) begin
        idx_r       <= '0;
        have_free_r <= 1'b0;
      end else if (cmd.scan) begin
        idx_r <= idx_r + 1'b1;
        if (is_free || free_now) begin
          have_free_r <= 1'b1;
        end
      end
      if (cmd.fin && !have_free_r && !full) begin
        used_cnt_r[f_r] <= cnt_cur + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.empty    = (cnt_cur == '0);
  assign stat.hit      = hit;
  assign stat.last     = ((CW'(idx_r) + CW'(1)) == cnt_cur);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_cur <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !have_free_r && !full) |=> (cnt_cur == $past(cnt_cur) + 1'b1))
    else $error("append did not grow the fill count");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.table_full) |->
      (out_res_r.entry_index == '0) && !out_res_r.resolved && !out_res_r.added &&
      !out_res_r.send_arp && (out_res_r.mac_out == '0))
    else $error("table full result carries entry data");
`endif

endmodule

// ----- hdl/arp_cache_with_aging.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// Per-interface IPv4 to MAC table with aging of resolved and pending entries.
// ----------------------------------------------------------------------------
// One request beat gives one result beat. A request walks the used slots of
// its interface in order, one slot per cycle through the single read port of
// the entry memory, and stops early on a hit. The next request is taken
// once the result has moved into the output register. No clearing pass
// follows reset: a per-interface fill count bounds every scan. Timeouts sit
// at byte addresses 0 (resolved) and 4 (pending); the user is to write them
// only while idle, and the block itself does not enforce it.
module arp_cache_with_aging #(
  parameter int ENTRIES = arpc_pkg::DEF_ENTRIES,
  parameter int IFACES  = arpc_pkg::DEF_IFACES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  arpc_in_if.sink                      in_ch,
  arpc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::DATA_W-1:0]  pwdata,
  output logic [arpc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int TMO_W  = arpc_pkg::TMO_W;
  localparam int DATA_W = arpc_pkg::DATA_W;

  logic [TMO_W-1:0]  ok_tmo_r;
  logic [TMO_W-1:0]  ng_tmo_r;
  logic              cfg_wr;
  arpc_pkg::cmd_t    cmd;
  arpc_pkg::stat_t   stat;
  arpc_pkg::result_t out_res;
  logic              out_valid;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_tmo_r <= arpc_pkg::OK_TMO_RST;
      ng_tmo_r <= arpc_pkg::NG_TMO_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == arpc_pkg::REG_NG_TMO) begin
        ng_tmo_r <= pwdata[TMO_W-1:0];
      end else begin
        ok_tmo_r <= pwdata[TMO_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == arpc_pkg::REG_OK_TMO) ? DATA_W'(ok_tmo_r) : DATA_W'(ng_tmo_r);

  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  arpc_dp #(
    .ENTRIES (ENTRIES),
    .IFACES  (IFACES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .ok_tmo      (ok_tmo_r),
    .ng_tmo      (ng_tmo_r),
    .in_iface    (in_ch.iface),
    .in_ip_addr  (in_ch.ip_addr),
    .in_has_mac  (in_ch.has_mac),
    .in_mac_addr (in_ch.mac_addr),
    .in_now_sec  (in_ch.now_sec),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .out_res     (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.entry_index = out_res.entry_index;
  assign out_ch.resolved    = out_res.resolved;
  assign out_ch.mac_out     = out_res.mac_out;
  assign out_ch.added       = out_res.added;
  assign out_ch.send_arp    = out_res.send_arp;
  assign out_ch.table_full  = out_res.table_full;

endmodule
